// File: sv/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // Latched press classification
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2
    } press_kind_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 8;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_DEBOUNCE   = cfg_index_t'(0);
    localparam cfg_index_t REG_LONG_PRESS = cfg_index_t'(1);
    localparam cfg_index_t REG_REFRESH    = cfg_index_t'(2);

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd40;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd300;
    localparam logic [15:0] REFRESH_RESET    = 16'd100;

    localparam logic [31:0] INT32_MIN = 32'h8000_0000;
    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

// File: sv/button_press_classifier.sv
`default_nettype none

// Button press classifier. Each input beat carries the millisecond time, the
// raw active-low switch level, the encoder delta and a take-press flag; each
// beat yields exactly one result beat with the latched press kind (when taken)
// and the negated, saturated encoder delta held at the last refresh. The switch
// is sampled only when more than debounce_ms has passed since the previous
// sample; a release before long_press_ms latches SHORT, a hold of long_press_ms
// or more latches LONG. One beat is accepted per cycle while the result is not
// stalled: the beat is captured in an input register, classified against the
// running state and written to the result register, which presents it as the
// result beat. A stalled result holds a full input stage and stalls the input in
// the same cycle. Configuration writes (index 0 debounce, 1 long press, 2
// refresh, others ignored) are always ready and must land only while idle.
module button_press_classifier
    import bpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire cfg_index_t         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        now_ms,
    input  wire logic               switch_level,
    input  wire logic signed [31:0] encoder_count,
    input  wire logic               take_press,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              press_kind,
    output logic signed [31:0]      turn_amount
);

    // Configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [15:0] refresh_reg;

    // Input stage
    logic        stage_valid_reg;
    logic [31:0] now_reg;
    logic        level_reg;
    logic [31:0] count_reg;
    logic        take_reg;

    // Classifier state
    logic [31:0] sample_time_reg,  sample_time_next;
    logic [31:0] press_start_reg,  press_start_next;
    logic [31:0] capture_time_reg, capture_time_next;
    logic        awaiting_reg,     awaiting_next;
    logic        was_pressed_reg,  was_pressed_next;
    press_kind_t pending_reg,      pending_next;
    logic [31:0] held_reg,         held_next;

    // Result register
    logic        out_valid_reg;
    press_kind_t kind_reg,         kind_next;
    logic [31:0] turn_reg,         turn_next;

    logic        advance;
    logic        pressed;
    logic        sample_due;
    logic        press_edge;
    logic [31:0] sample_gap;
    logic [31:0] press_gap;
    logic [31:0] hold_gap;
    logic [31:0] capture_gap;
    logic [31:0] long_limit;

    assign cfg_ready = 1'b1;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            refresh_reg    <= REFRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_REFRESH:    refresh_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Move the staged beat on when the result slot is free or being emptied
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;

    // Capture input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            now_reg   <= now_ms;
            level_reg <= switch_level;
            count_reg <= encoder_count;
            take_reg  <= take_press;
        end
    end

    // Classify the staged beat against the running state
    assign pressed     = !level_reg;
    assign long_limit  = {16'd0, long_press_reg};
    assign sample_gap  = now_reg - sample_time_reg;
    assign press_gap   = now_reg - press_start_reg;
    assign capture_gap = now_reg - capture_time_reg;
    assign sample_due  = sample_gap > {16'd0, debounce_reg};
    assign press_edge  = sample_due && (pressed != was_pressed_reg);
    // A fresh press restarts the hold timer at this very sample
    assign hold_gap    = (press_edge && pressed) ? 32'd0 : press_gap;

    always_comb
    begin
        sample_time_next  = sample_time_reg;
        press_start_next  = press_start_reg;
        capture_time_next = capture_time_reg;
        awaiting_next     = awaiting_reg;
        was_pressed_next  = was_pressed_reg;
        pending_next      = pending_reg;
        held_next         = held_reg;
        kind_next         = KIND_NONE;

        if (sample_due)
        begin
            sample_time_next = now_reg;
            if (press_edge)
            begin
                if (pressed)
                begin
                    press_start_next = now_reg;
                    awaiting_next    = 1'b1;
                end
                else if (press_gap < long_limit)
                begin
                    pending_next  = KIND_SHORT;
                    awaiting_next = 1'b0;
                end
                was_pressed_next = pressed;
            end
            if ((hold_gap >= long_limit) && awaiting_next)
            begin
                pending_next  = KIND_LONG;
                awaiting_next = 1'b0;
            end
        end

        // Refresh the held encoder delta
        if (capture_gap >= {16'd0, refresh_reg})
        begin
            held_next         = count_reg;
            capture_time_next = now_reg;
        end

        // Hand over and clear the latched kind
        if (take_reg)
        begin
            kind_next    = pending_next;
            pending_next = KIND_NONE;
        end

        // Negate with saturation of the most negative value
        if (held_next == INT32_MIN)
        begin
            turn_next = INT32_MAX;
        end
        else
        begin
            turn_next = 32'd0 - held_next;
        end
    end

    // Update state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_time_reg  <= '0;
            press_start_reg  <= '0;
            capture_time_reg <= '0;
            awaiting_reg     <= 1'b0;
            was_pressed_reg  <= 1'b0;
            pending_reg      <= KIND_NONE;
            held_reg         <= '0;
        end
        else if (advance)
        begin
            sample_time_reg  <= sample_time_next;
            press_start_reg  <= press_start_next;
            capture_time_reg <= capture_time_next;
            awaiting_reg     <= awaiting_next;
            was_pressed_reg  <= was_pressed_next;
            pending_reg      <= pending_next;
            held_reg         <= held_next;
        end
    end

    // Hold or load the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= kind_next;
            turn_reg <= turn_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign press_kind  = kind_reg;
    assign turn_amount = turn_reg;

`ifndef ASSERT_OFF
    // A long-press wait is only armed while the switch is held down
    assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> was_pressed_reg)
        else $error("long-press wait armed while released");

    // The negated delta never shows the most negative value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (turn_amount != INT32_MIN))
        else $error("turn amount not saturated");

    // A staged beat with a free result slot reaches the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("staged beat lost");

    // Input is only held back by a full stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && out_valid_reg && out_stall))
        else $error("spurious input stall");
`endif

endmodule

`default_nettype wire

// File: tb/sv/button_press_classifier_tb.sv
import bpc_pkg::*;

// One expected result beat
typedef struct {
    press_kind_t        kind;
    logic signed [31:0] turn;
} press_result_t;

// Press classifier predictor plus the queue of results it has promised
class press_scoreboard;
    bit [15:0]     debounce_ms;
    bit [15:0]     long_ms;
    bit [15:0]     refresh_period;
    bit [31:0]     last_sample;
    bit [31:0]     press_start;
    bit [31:0]     last_capture;
    bit [31:0]     held_delta;
    bit            wait_long;
    bit            was_down;
    press_kind_t   latched;
    press_result_t expected_q[$];
    int            mismatches;
    int            beats;
    int            results;
    int            writes;

    function new();
        debounce_ms    = DEBOUNCE_RESET;
        long_ms        = LONG_PRESS_RESET;
        refresh_period = REFRESH_RESET;
        last_sample    = '0;
        press_start    = '0;
        last_capture   = '0;
        held_delta     = '0;
        wait_long      = 1'b0;
        was_down       = 1'b0;
        latched        = KIND_NONE;
        mismatches     = 0;
        beats          = 0;
        results        = 0;
        writes         = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void flag(string msg);
        if (mismatches < 10)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    // Track a register write; unknown indexes are dropped
    function void set_reg(cfg_index_t idx, logic [15:0] data);
        writes++;
        case (idx)
            REG_DEBOUNCE:   debounce_ms    = data;
            REG_LONG_PRESS: long_ms        = data;
            REG_REFRESH:    refresh_period = data;
            default:        ;
        endcase
    endfunction

    // Advance the classifier by one accepted input beat
    function void note_beat(logic [31:0] now, logic sw, logic [31:0] cnt, logic take);
        press_result_t r;
        bit            down;
        bit [31:0]     since;
        bit [31:0]     held;

        beats++;
        down  = (sw == 1'b0);
        since = now - last_sample;
        // Sample the switch once the debounce interval is strictly exceeded
        if (since > 32'(debounce_ms)) begin
            last_sample = now;
            if (down != was_down) begin
                if (down) begin
                    press_start = now;
                    wait_long   = 1'b1;
                end
                else if ((now - press_start) < 32'(long_ms)) begin
                    latched   = KIND_SHORT;
                    wait_long = 1'b0;
                end
                was_down = down;
            end
            held = now - press_start;
            if (held >= 32'(long_ms) && wait_long) begin
                latched   = KIND_LONG;
                wait_long = 1'b0;
            end
        end
        // Capture the encoder delta on refresh
        if ((now - last_capture) >= 32'(refresh_period)) begin
            held_delta   = cnt;
            last_capture = now;
        end
        r.kind = KIND_NONE;
        if (take) begin
            r.kind  = latched;
            latched = KIND_NONE;
        end
        r.turn = (held_delta == INT32_MIN) ? INT32_MAX : (32'd0 - held_delta);
        expected_q.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [1:0] kind, logic [31:0] turn);
        press_result_t r;

        results++;
        if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result kind=%0d turn=%0d", kind, $signed(turn)));
            return;
        end
        r = expected_q.pop_front();
        if (kind !== r.kind)
            flag($sformatf("press_kind expected %0d actual %0d", r.kind, kind));
        if (turn !== r.turn)
            flag($sformatf("turn_amount expected %0d actual %0d", r.turn, $signed(turn)));
    endfunction
endclass

module button_press_classifier_tb;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index     = '0;
    logic [15:0]        cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [31:0]        now_ms        = '0;
    logic               switch_level  = 1'b1;
    logic signed [31:0] encoder_count = '0;
    logic               take_press    = 1'b0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [1:0]         press_kind;
    logic signed [31:0] turn_amount;

    press_scoreboard sb = new();

    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        phases    = 0;
    bit [31:0] clock_ms  = '0;
    bit        level     = 1'b1;

    button_press_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .now_ms        (now_ms),
        .switch_level  (switch_level),
        .encoder_count (encoder_count),
        .take_press    (take_press),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .press_kind    (press_kind),
        .turn_amount   (turn_amount)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(8 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Random back-pressure on the result side
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watch every handshake and feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_beat(now_ms, switch_level, encoder_count, take_press);
            if (out_valid && !out_stall)
                sb.check_result(press_kind, turn_amount);
        end
    end

    // Hold one register write until the block takes it; callers drop valid after the last one
    task automatic program_reg(cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drain all results, then let the pipeline settle
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Present one input beat, idling first at the current rate
    task automatic send_beat(logic [31:0] now, logic sw, logic [31:0] cnt, logic take);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= now;
        switch_level  <= sw;
        encoder_count <= cnt;
        take_press    <= take;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic configure(logic [15:0] deb, logic [15:0] lng, logic [15:0] rfs);
        wait_idle();
        program_reg(REG_DEBOUNCE, deb);
        program_reg(REG_LONG_PRESS, lng);
        program_reg(REG_REFRESH, rfs);
        program_reg(cfg_index_t'($urandom_range(3, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        phases++;
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return INT32_MIN;
            1:       return INT32_MAX;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Time step sized around one of the active intervals
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'(sb.debounce_ms) + 2);
            1:       return $urandom_range(0, 32'(sb.long_ms) + 2);
            2:       return $urandom_range(0, 32'(sb.refresh_period) + 2);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    // Edge cases under reset settings, then a zero long limit, then the reset limit again
    task automatic run_directed();
        send_beat(32'd0,    1'b1, 32'd0,        1'b1);
        send_beat(32'd50,   1'b0, INT32_MIN,    1'b0);
        send_beat(32'd100,  1'b0, INT32_MIN,    1'b0);
        send_beat(32'd200,  1'b1, INT32_MAX,    1'b1);
        send_beat(32'd210,  1'b1, 32'hFFFF_FFFF, 1'b1);
        send_beat(32'd300,  1'b0, 32'd0,        1'b0);
        send_beat(32'd700,  1'b0, 32'd1,        1'b0);
        send_beat(32'd710,  1'b0, 32'd2,        1'b0);
        send_beat(32'd800,  1'b1, 32'd0,        1'b1);
        send_beat(32'd900,  1'b0, 32'd5,        1'b0);
        send_beat(32'd1300, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_beat(32'd1340, 1'b0, 32'd7,        1'b0);
        send_beat(32'd1341, 1'b0, INT32_MAX,    1'b0);
        send_beat(32'd1640, 1'b1, 32'd9,        1'b1);
        send_beat(32'hFFFF_FFF0, 1'b0, INT32_MIN, 1'b0);
        send_beat(32'h0000_0100, 1'b1, 32'hFFFF_FFFF, 1'b1);
        in_valid <= 1'b0;
        wait_idle();
        program_reg(REG_LONG_PRESS, 16'd0);
        program_reg(cfg_index_t'(8'hFF), 16'hFFFF);
        program_reg(cfg_index_t'(8'h03), 16'h0000);
        cfg_valid <= 1'b0;
        send_beat(32'h0000_0200, 1'b0, 32'd3,  1'b0);
        send_beat(32'h0000_0210, 1'b0, 32'd4,  1'b1);
        send_beat(32'h0000_0300, 1'b1, 32'd11, 1'b1);
        in_valid <= 1'b0;
        wait_idle();
        program_reg(REG_LONG_PRESS, LONG_PRESS_RESET);
        cfg_valid <= 1'b0;
        clock_ms = 32'h0000_0300;
        level    = 1'b1;
    endtask

    // Mostly a plausible button with random content, some time jumps
    task automatic run_random(int count);
        int        pick;
        bit [31:0] now;

        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                clock_ms = clock_ms + pick_step();
                if ($urandom_range(0, 4) == 0)
                    level = ~level;
                now = clock_ms;
            end
            else if (pick < 95)
            begin
                now   = $urandom;
                level = 1'($urandom_range(0, 1));
            end
            else
            begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
                now      = clock_ms;
            end
            send_beat(now, level, pick_count(), ($urandom_range(0, 3) == 0));
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();

        // Walk through settings, extremes first, rotating idle and stall patterns
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0:       configure(DEBOUNCE_RESET, LONG_PRESS_RESET, REFRESH_RESET);
                1:       configure(16'd0, 16'd0, 16'd0);
                2:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3:       configure(16'hFFFF, 16'd0, 16'hFFFF);
                4:       configure(16'd0, 16'hFFFF, 16'd1);
                default: configure(16'($urandom_range(0, 50)), 16'($urandom_range(0, 400)),
                                   16'($urandom_range(0, 120)));
            endcase
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            run_random(150);
        end

        // Drain and give late results a chance to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d input beats and %0d result beats over %0d setting phases",
                 sb.beats, sb.results, phases);
        $display("%0d register writes, %0d mismatches", sb.writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
